@@ hw/rtl/plu_pkg.sv @@
// Shared types, sizing constants and the palette ROM for the line upscaler.
// Used by every module of the block; depends on nothing.
package plu_pkg;

  // Line geometry
  localparam int SRC_WIDTH = 256;
  localparam int DST_WIDTH = 320;

  // Field widths
  localparam int ROW_IN_W  = 8;
  localparam int IDX_W     = 8;
  localparam int ROW_OUT_W = 9;
  localparam int COL_OUT_W = 9;
  localparam int RGB_W     = 16;

  // Column counter must hold DST_WIDTH itself (line full)
  localparam int COL_W = $clog2(DST_WIDTH + 1);

  // Error stays below DST_WIDTH when upscaling; when downscaling it grows by
  // at most SRC_WIDTH per column over one line.
  localparam int ERR_BOUND = (SRC_WIDTH < DST_WIDTH) ? DST_WIDTH : DST_WIDTH * SRC_WIDTH;
  localparam int ERR_W     = $clog2(ERR_BOUND + SRC_WIDTH + 1);

  localparam logic [ERR_W-1:0] SRC_E = ERR_W'(SRC_WIDTH);
  localparam logic [ERR_W-1:0] DST_E = ERR_W'(DST_WIDTH);
  localparam logic [COL_W-1:0] DST_C = COL_W'(DST_WIDTH);

  // Job queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // One classified source pixel: one or two columns, one or two rows each
  typedef struct packed {
    logic [ROW_OUT_W-1:0] row;
    logic [COL_W-1:0]     col;
    logic                 two_cols;
    logic                 two_rows;
    logic [RGB_W-1:0]     rgb;
  } job_t;

  // 64-entry RGB565 palette
  function automatic logic [RGB_W-1:0] palette(input logic [5:0] idx);
    logic [RGB_W-1:0] c;
    case (idx)
      6'd0:  c = 16'h52aa; 6'd1:  c = 16'h010e; 6'd2:  c = 16'h0093; 6'd3:  c = 16'h3011;
      6'd4:  c = 16'h400c; 6'd5:  c = 16'h6006; 6'd6:  c = 16'h6000; 6'd7:  c = 16'h4080;
      6'd8:  c = 16'h2180; 6'd9:  c = 16'h0220; 6'd10: c = 16'h0220; 6'd11: c = 16'h0220;
      6'd12: c = 16'h0188; 6'd13: c = 16'h0000; 6'd14: c = 16'h0000; 6'd15: c = 16'h0000;
      6'd16: c = 16'h9cd3; 6'd17: c = 16'h02b9; 6'd18: c = 16'h319f; 6'd19: c = 16'h611d;
      6'd20: c = 16'h8897; 6'd21: c = 16'ha88c; 6'd22: c = 16'ha904; 6'd23: c = 16'h7220;
      6'd24: c = 16'h5320; 6'd25: c = 16'h23a0; 6'd26: c = 16'h0440; 6'd27: c = 16'h03a4;
      6'd28: c = 16'h032e; 6'd29: c = 16'h0000; 6'd30: c = 16'h0000; 6'd31: c = 16'h0000;
      6'd32: c = 16'hffff; 6'd33: c = 16'h555f; 6'd34: c = 16'h745f; 6'd35: c = 16'hbb3f;
      6'd36: c = 16'heabf; 6'd37: c = 16'hfab7; 6'd38: c = 16'hfbac; 6'd39: c = 16'hdc44;
      6'd40: c = 16'hadc0; 6'd41: c = 16'h7660; 6'd42: c = 16'h56e4; 6'd43: c = 16'h36ee;
      6'd44: c = 16'h35db; 6'd45: c = 16'h4228; 6'd46: c = 16'h0000; 6'd47: c = 16'h0000;
      6'd48: c = 16'hffff; 6'd49: c = 16'haeff; 6'd50: c = 16'hce7f; 6'd51: c = 16'hdddf;
      6'd52: c = 16'hfddf; 6'd53: c = 16'hfddb; 6'd54: c = 16'hfdd7; 6'd55: c = 16'hee73;
      6'd56: c = 16'hdeee; 6'd57: c = 16'hbf6e; 6'd58: c = 16'haf73; 6'd59: c = 16'h9f77;
      6'd60: c = 16'haefd; 6'd61: c = 16'had55; 6'd62: c = 16'h0000; 6'd63: c = 16'h0000;
      default: c = 16'h0000;
    endcase
    return c;
  endfunction

endpackage

@@ hw/rtl/plu_front.sv @@
// Front end: palette lookup, row mapping and Bresenham column stepping.
// Emits one job per source pixel that covers any column; uses plu_pkg.
module plu_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [plu_pkg::ROW_IN_W-1:0]  src_row,
  input  logic [plu_pkg::IDX_W-1:0]     color_index,
  input  logic                          line_start,
  output logic                          job_push,
  output plu_pkg::job_t                 job
);

  logic [plu_pkg::ERR_W-1:0] step_error, step_error_next;
  logic [plu_pkg::COL_W-1:0] next_column, next_column_next;

  logic [plu_pkg::ERR_W-1:0] e0, sum1, e1, sum2, e2;
  logic [plu_pkg::COL_W-1:0] c0, c1, c2;
  logic                      full0, full1, ge1, ge2, one_col;
  logic [plu_pkg::ROW_IN_W+2:0] row5;

  // Start of line clears the stepping state first
  assign e0 = line_start ? '0 : step_error;
  assign c0 = line_start ? '0 : next_column;

  // First column
  assign full0 = c0 >= plu_pkg::DST_C;
  assign c1    = c0 + 1'b1;
  assign full1 = c1 >= plu_pkg::DST_C;
  assign sum1  = e0 + plu_pkg::SRC_E;
  assign ge1   = sum1 >= plu_pkg::DST_E;
  assign e1    = ge1 ? (sum1 - plu_pkg::DST_E) : sum1;

  // Second column, taken when error is still short and line not full
  assign c2    = c1 + 1'b1;
  assign sum2  = e1 + plu_pkg::SRC_E;
  assign ge2   = sum2 >= plu_pkg::DST_E;
  assign e2    = ge2 ? (sum2 - plu_pkg::DST_E) : sum2;

  assign one_col = ge1 | full1;

  always_comb begin
    if (full0) begin
      step_error_next  = e0;
      next_column_next = c0;
    end else if (one_col) begin
      step_error_next  = e1;
      next_column_next = c1;
    end else begin
      step_error_next  = e2;
      next_column_next = c2;
    end
  end

  // Row times five over four
  assign row5 = {3'b000, src_row} + {1'b0, src_row, 2'b00};

  assign job_push     = accept & ~full0;
  assign job.row      = row5[plu_pkg::ROW_IN_W+2:2];
  assign job.col      = c0;
  assign job.two_cols = ~one_col;
  assign job.two_rows = (src_row[1:0] == 2'b11);
  assign job.rgb      = plu_pkg::palette(color_index[5:0]);

  // Stepping state
  always_ff @(posedge clk) begin
    if (rst) begin
      step_error  <= '0;
      next_column <= '0;
    end else if (accept) begin
      step_error  <= step_error_next;
      next_column <= next_column_next;
    end
  end

endmodule

@@ hw/rtl/plu_job_fifo.sv @@
// Short job queue between front and back end.
// Register-based ring of plu_pkg::FIFO_DEPTH entries; uses plu_pkg.
module plu_job_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  plu_pkg::job_t wr_data,
  input  logic          rd_en,
  output plu_pkg::job_t rd_data,
  output logic          is_full,
  output logic          not_empty
);

  plu_pkg::job_t                mem [plu_pkg::FIFO_DEPTH];
  logic [plu_pkg::PTR_W-1:0]    wr_ptr, rd_ptr;
  logic [plu_pkg::CNT_W-1:0]    count;

  assign is_full   = (count == plu_pkg::CNT_W'(plu_pkg::FIFO_DEPTH));
  assign not_empty = (count != '0);
  assign rd_data   = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == plu_pkg::PTR_W'(plu_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == plu_pkg::PTR_W'(plu_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/plu_back.sv @@
// Back end: expands each job into one to four output words, one per cycle
// while the output is free or popped, held until popped. Uses plu_pkg.
module plu_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           job_valid,
  input  plu_pkg::job_t                  job,
  output logic                           job_pop,
  input  logic                           pop,
  output logic                           empty,
  output logic [plu_pkg::ROW_OUT_W-1:0]  out_row,
  output logic [plu_pkg::COL_OUT_W-1:0]  out_col,
  output logic [plu_pkg::RGB_W-1:0]      rgb_color,
  output logic                           last
);

  logic                      out_valid;
  logic                      col_sel, row_sel;
  logic                      load, word_last;
  logic [plu_pkg::COL_W-1:0] col_sum;

  // Output register free or being drained
  assign load      = job_valid & (~out_valid | pop);
  assign word_last = (~job.two_rows | row_sel) & (~job.two_cols | col_sel);
  assign job_pop   = load & word_last;
  assign col_sum   = job.col + plu_pkg::COL_W'(col_sel);
  assign empty     = ~out_valid;

  // Word position within the job: rows inner, columns outer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      col_sel   <= 1'b0;
      row_sel   <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        if (word_last) begin
          col_sel <= 1'b0;
          row_sel <= 1'b0;
        end else if (job.two_rows && !row_sel) begin
          row_sel <= 1'b1;
        end else begin
          row_sel <= 1'b0;
          col_sel <= 1'b1;
        end
      end
    end
  end

  // Output word payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_row   <= job.row + plu_pkg::ROW_OUT_W'(row_sel);
      out_col   <= plu_pkg::COL_OUT_W'(col_sum);
      rgb_color <= job.rgb;
      last      <= word_last;
    end
  end

endmodule

@@ hw/rtl/palette_line_upscaler.sv @@
// Top level of the palette line upscaler: front end, job queue, back end.
// Depends on plu_pkg, plu_front, plu_job_fifo and plu_back.
//
//  channel | handshake        | words
//  --------+------------------+------------------------------------------
//  input   | push / full      | src_row, color_index, line_start
//  result  | empty / pop      | out_row, out_col, rgb_color, last
//
// A pixel is taken every cycle while the job queue has room; the back end
// writes one output word per cycle unless a word waits unpopped, and a
// pixel yields one to four words (columns times rows), about 2.5 words
// per pixel on doubled rows at 256 to 320, via queue then output register.
// Synchronous reset clears the stepping state, queue and output register.
// A stalled pop holds the output word and backs up into full after two jobs.
module palette_line_upscaler (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [plu_pkg::ROW_IN_W-1:0]   src_row,
  input  logic [plu_pkg::IDX_W-1:0]      color_index,
  input  logic                           line_start,
  output logic                           empty,
  input  logic                           pop,
  output logic [plu_pkg::ROW_OUT_W-1:0]  out_row,
  output logic [plu_pkg::COL_OUT_W-1:0]  out_col,
  output logic [plu_pkg::RGB_W-1:0]      rgb_color,
  output logic                           last
);

  plu_pkg::job_t job_in, job_out;
  logic          accept, job_push, job_pop, job_valid, q_full;

  assign full   = q_full;
  assign accept = push & ~q_full;

  // Classify pixels
  plu_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .src_row     (src_row),
    .color_index (color_index),
    .line_start  (line_start),
    .job_push    (job_push),
    .job         (job_in)
  );

  // Job queue
  plu_job_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (job_push),
    .wr_data   (job_in),
    .rd_en     (job_pop),
    .rd_data   (job_out),
    .is_full   (q_full),
    .not_empty (job_valid)
  );

  // Expand jobs into output words
  plu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job_out),
    .job_pop   (job_pop),
    .pop       (pop),
    .empty     (empty),
    .out_row   (out_row),
    .out_col   (out_col),
    .rgb_color (rgb_color),
    .last      (last)
  );

endmodule

@@ hw/rtl/plu_checker.sv @@
// Port-level checks for the palette line upscaler, bound to the top level.
// Depends on plu_pkg and palette_line_upscaler.
module plu_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           empty,
  input logic                           pop,
  input logic [plu_pkg::ROW_OUT_W-1:0]  out_row,
  input logic [plu_pkg::COL_OUT_W-1:0]  out_col,
  input logic [plu_pkg::RGB_W-1:0]      rgb_color,
  input logic                           last
);

  // Reset leaves no word waiting
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result not empty after reset");

  // A waiting word stays until popped
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("result dropped without pop");

  // A stalled word keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> ($stable(out_row) && $stable(out_col) &&
                          $stable(rgb_color) && $stable(last)))
    else $error("result payload changed while stalled");

  // Columns stay inside the destination line
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (int'(out_col) < plu_pkg::DST_WIDTH))
    else $error("output column beyond line width");

endmodule

bind palette_line_upscaler plu_checker u_plu_checker (
  .clk       (clk),
  .rst       (rst),
  .empty     (empty),
  .pop       (pop),
  .out_row   (out_row),
  .out_col   (out_col),
  .rgb_color (rgb_color),
  .last      (last)
);
